/* sv/qtue_pkg.sv */
package qtue_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_CONNECT = 2'd1,
        CMD_SELECT  = 2'd2,
        CMD_UPDATE  = 2'd3
    } cmd_t;

    localparam logic [1:0] R_NONE = 2'd0;
    localparam logic [1:0] R_ZERO = 2'd1;
    localparam logic [1:0] R_GOAL = 2'd2;

    localparam logic [0:0] CFG_END      = 1'b0;
    localparam logic [0:0] CFG_DISCOUNT = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  first_location;
        logic [3:0]  second_location;
        logic [15:0] random_value;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [23:0] new_q;
        logic signed [23:0] score;
        logic               status;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CONN,
        ST_SEL_CNT,
        ST_SEL_DIV,
        ST_SEL_PICK,
        ST_UPD_ROW,
        ST_UPD_MUL,
        ST_UPD_WR,
        ST_UPD_SCAN,
        ST_UPD_DIV,
        ST_DONE
    } state_t;

    // request from the sequencer to the serial divider
    typedef struct packed {
        logic        start;
    } div_ctl_t;

endpackage

/* sv/q_table_update_engine.sv */
// table sweeps visit one entry a cycle, the clear and update sweeps over every
// memory entry (LOCATIONS taken up to a power of two); select and update also
// wait on the serial divider
// throughput: one word at a time; the next word is taken once the result
// has moved into the output register, a full output register holds the last step
// reset: synchronous active low; control cleared, then a clearing pass over
// every memory entry rewrites both tables before the first word is taken
module q_table_update_engine #(
    parameter int LOCATIONS = 16,
    parameter int Q_WIDTH   = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qtue_pkg::in_word_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qtue_pkg::out_word_t m_data,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    localparam int LW    = $clog2(LOCATIONS);
    localparam int AW    = 2 * LW;
    localparam int SWEEP = 2 ** AW;               // every memory entry
    localparam int CW    = AW + 1;
    localparam int SW    = Q_WIDTH + AW + 1;     // sum width
    localparam int PW    = SW + 15;              // sum * 25600 width
    localparam int DW    = 64;
    localparam int RCW   = $clog2(LOCATIONS + 1);
    localparam int NW    = Q_WIDTH + 10;         // new value before saturation
    localparam logic signed [Q_WIDTH-1:0] QMAX = {1'b0, {(Q_WIDTH-1){1'b1}}};
    localparam logic signed [Q_WIDTH-1:0] QMIN = {1'b1, {(Q_WIDTH-1){1'b0}}};

    // configuration registers
    logic [3:0] end_reg;
    logic [7:0] disc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_reg  <= 4'd15;
            disc_reg <= 8'd205;
        end else if (cfg_we) begin
            case (cfg_index)
                qtue_pkg::CFG_END:      end_reg  <= cfg_data[3:0];
                qtue_pkg::CFG_DISCOUNT: disc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // command held for the whole sequence
    qtue_pkg::state_t state_reg, state_next;
    qtue_pkg::in_word_t cmd_reg;
    logic [LW-1:0] a_loc, b_loc;
    logic a_ok, b_ok, end_ok;
    assign a_ok   = int'(cmd_reg.first_location) < LOCATIONS;
    assign b_ok   = int'(cmd_reg.second_location) < LOCATIONS;
    assign end_ok = int'(end_reg) < LOCATIONS;
    assign a_loc  = LW'(cmd_reg.first_location);
    assign b_loc  = LW'(cmd_reg.second_location);

    // sweep counter: issue index and a registered copy that lines up with the read data
    logic [CW-1:0] idx_reg, idx_next;
    logic          rv_reg, rv_next;       // read data valid this cycle
    logic [CW-1:0] ridx_reg;
    logic          step_reg, step_next;   // second connect write

    // memory ports
    logic [AW-1:0] r_raddr, r_waddr, q_raddr, q_waddr;
    logic [1:0]    r_rdata, r_wdata;
    logic          r_we, q_we;
    logic signed [Q_WIDTH-1:0] q_rdata, q_wdata;

    qtue_mem #(.AW(AW), .QW(Q_WIDTH)) u_mem (
        .aclk    (aclk),
        .r_raddr (r_raddr), .r_rdata (r_rdata),
        .r_we    (r_we), .r_waddr (r_waddr), .r_wdata (r_wdata),
        .q_raddr (q_raddr), .q_rdata (q_rdata),
        .q_we    (q_we), .q_waddr (q_waddr), .q_wdata (q_wdata)
    );

    // accumulators
    logic [RCW-1:0] cnt_reg, cnt_next;          // connected columns
    logic [RCW-1:0] pick_reg, pick_next;
    logic [3:0]     act_reg, act_next;
    logic           found_reg, found_next;
    logic signed [Q_WIDTH-1:0] rmax_reg, rmax_next;
    logic [1:0]     rcode_reg, rcode_next;
    logic signed [Q_WIDTH+8:0] prod_reg, prod_next;
    logic signed [Q_WIDTH-1:0] newq_reg, newq_next;
    logic signed [SW-1:0]      sum_reg, sum_next;
    logic signed [Q_WIDTH-1:0] tmax_reg, tmax_next;
    logic           neg_reg, neg_next;

    // divider
    qtue_pkg::div_ctl_t div_ctl;
    logic [DW-1:0] div_a, div_b, div_q, div_r;
    logic          div_busy, div_wait_reg, div_wait_next;

    qtue_div #(.W(DW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_ctl.start),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // output register
    logic                out_valid_reg, out_valid_next;
    qtue_pkg::out_word_t out_reg, out_next;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign s_ready = (state_reg == qtue_pkg::ST_IDLE);

    // helpers
    logic [AW-1:0] sweep_addr, row_b_addr, row_a_addr;
    assign sweep_addr = idx_reg[AW-1:0];
    assign row_b_addr = {b_loc, idx_reg[LW-1:0]};
    assign row_a_addr = {a_loc, idx_reg[LW-1:0]};

    // sweep entry that belongs to the table
    logic scan_ok;
    assign scan_ok = (int'(ridx_reg[AW-1:LW]) < LOCATIONS)
                  && (int'(ridx_reg[LW-1:0]) < LOCATIONS);

    logic signed [NW-1:0]      newq_wide;
    logic signed [PW-1:0]      scaled;
    logic [PW-1:0]             mag;
    logic signed [DW:0]        qsigned;

    always_comb begin
        newq_wide = NW'(prod_reg >>> 8);
        case (rcode_reg)
            qtue_pkg::R_GOAL: newq_wide = newq_wide + NW'(25600);
            qtue_pkg::R_ZERO: newq_wide = newq_wide;
            default:          newq_wide = newq_wide - NW'(256);
        endcase
        scaled = PW'(sum_reg) * PW'(25600);
        mag    = scaled[PW-1] ? PW'(-scaled) : scaled;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qtue_pkg::ST_IDLE:
                if (s_valid && s_ready) begin
                    case (s_data.cmd)
                        qtue_pkg::CMD_CLEAR:   state_next = qtue_pkg::ST_CLEAR;
                        qtue_pkg::CMD_CONNECT: state_next = qtue_pkg::ST_CONN;
                        qtue_pkg::CMD_SELECT:  state_next = qtue_pkg::ST_SEL_CNT;
                        default:               state_next = qtue_pkg::ST_UPD_ROW;
                    endcase
                end
            qtue_pkg::ST_CLEAR:
                if (idx_reg == CW'(SWEEP - 1)) state_next = qtue_pkg::ST_DONE;
            qtue_pkg::ST_CONN:
                if (!(a_ok && b_ok) || step_reg) state_next = qtue_pkg::ST_DONE;
            qtue_pkg::ST_SEL_CNT:
                if (!a_ok) state_next = qtue_pkg::ST_DONE;
                else if (rv_reg && ridx_reg == CW'(LOCATIONS - 1)) begin
                    state_next = qtue_pkg::ST_SEL_DIV;
                end
            qtue_pkg::ST_SEL_DIV:
                if (cnt_reg == '0) state_next = qtue_pkg::ST_DONE;
                else if (div_wait_reg && !div_busy) state_next = qtue_pkg::ST_SEL_PICK;
            qtue_pkg::ST_SEL_PICK:
                if (rv_reg && ridx_reg == CW'(LOCATIONS - 1)) begin
                    state_next = qtue_pkg::ST_DONE;
                end
            qtue_pkg::ST_UPD_ROW:
                if (!(a_ok && b_ok)) state_next = qtue_pkg::ST_DONE;
                else if (rv_reg && ridx_reg == CW'(LOCATIONS - 1)) begin
                    state_next = qtue_pkg::ST_UPD_MUL;
                end
            qtue_pkg::ST_UPD_MUL:  state_next = qtue_pkg::ST_UPD_WR;
            qtue_pkg::ST_UPD_WR:   state_next = qtue_pkg::ST_UPD_SCAN;
            qtue_pkg::ST_UPD_SCAN:
                if (rv_reg && ridx_reg == CW'(SWEEP - 1)) begin
                    state_next = qtue_pkg::ST_UPD_DIV;
                end
            qtue_pkg::ST_UPD_DIV:
                if (!div_wait_reg && tmax_reg == '0) state_next = qtue_pkg::ST_DONE;
                else if (div_wait_reg && !div_busy) state_next = qtue_pkg::ST_DONE;
            qtue_pkg::ST_DONE:
                // wait here while the output register still holds an untaken word
                if (!out_valid_reg || m_ready) state_next = qtue_pkg::ST_IDLE;
            default: state_next = qtue_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        idx_next       = idx_reg;
        rv_next        = 1'b0;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        pick_next      = pick_reg;
        act_next       = act_reg;
        found_next     = found_reg;
        rmax_next      = rmax_reg;
        rcode_next     = rcode_reg;
        prod_next      = prod_reg;
        newq_next      = newq_reg;
        sum_next       = sum_reg;
        tmax_next      = tmax_reg;
        neg_next       = neg_reg;
        div_wait_next  = div_wait_reg;
        div_ctl        = '0;
        div_a          = '0;
        div_b          = '0;
        r_raddr        = '0;
        q_raddr        = '0;
        r_we           = 1'b0;
        r_waddr        = '0;
        r_wdata        = qtue_pkg::R_NONE;
        q_we           = 1'b0;
        q_waddr        = '0;
        q_wdata        = '0;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        qsigned        = '0;

        if (m_valid && m_ready) out_valid_next = 1'b0;

        case (state_reg)
            qtue_pkg::ST_IDLE: begin
                idx_next  = '0;
                step_next = 1'b0;
                cnt_next  = '0;
                sum_next  = '0;
                act_next  = '0;
                found_next = 1'b0;
                div_wait_next = 1'b0;
            end
            qtue_pkg::ST_CLEAR: begin
                // one entry of each table a cycle
                r_we    = 1'b1;
                r_waddr = sweep_addr;
                r_wdata = (end_ok && sweep_addr == {LW'(end_reg), LW'(end_reg)})
                          ? qtue_pkg::R_GOAL : qtue_pkg::R_NONE;
                q_we    = 1'b1;
                q_waddr = sweep_addr;
                q_wdata = '0;
                idx_next = idx_reg + 1'b1;
            end
            qtue_pkg::ST_CONN: begin
                if (a_ok && b_ok) begin
                    r_we = 1'b1;
                    if (!step_reg) begin
                        r_waddr = {b_loc, a_loc};
                        r_wdata = qtue_pkg::R_ZERO;
                    end else begin
                        r_waddr = {a_loc, b_loc};
                        r_wdata = (cmd_reg.second_location == end_reg)
                                  ? qtue_pkg::R_GOAL : qtue_pkg::R_ZERO;
                    end
                end
                step_next = 1'b1;
            end
            qtue_pkg::ST_SEL_CNT: begin
                r_raddr = row_a_addr;
                if (idx_reg < CW'(LOCATIONS)) begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg && r_rdata != qtue_pkg::R_NONE) cnt_next = cnt_reg + 1'b1;
                if (state_next == qtue_pkg::ST_SEL_DIV) idx_next = '0;
            end
            qtue_pkg::ST_SEL_DIV: begin
                if (!div_wait_reg && cnt_reg != '0) begin
                    div_ctl.start = 1'b1;
                    div_a = DW'(cmd_reg.random_value);
                    div_b = DW'(cnt_reg);
                    div_wait_next = 1'b1;
                end
                if (div_wait_reg && !div_busy) begin
                    pick_next = div_r[RCW-1:0];
                    idx_next  = '0;
                end
            end
            qtue_pkg::ST_SEL_PICK: begin
                r_raddr = row_a_addr;
                if (idx_reg < CW'(LOCATIONS)) begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg && r_rdata != qtue_pkg::R_NONE && !found_reg) begin
                    if (pick_reg == '0) begin
                        found_next = 1'b1;
                        act_next   = 4'(ridx_reg[LW-1:0]);
                    end else begin
                        pick_next = pick_reg - 1'b1;
                    end
                end
            end
            qtue_pkg::ST_UPD_ROW: begin
                // row b of q for its maximum; reward (a,b) read alongside
                q_raddr = row_b_addr;
                r_raddr = {a_loc, b_loc};
                if (idx_reg < CW'(LOCATIONS)) begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg) begin
                    rcode_next = r_rdata;
                    if (ridx_reg == '0 || q_rdata > rmax_reg) rmax_next = q_rdata;
                end
            end
            qtue_pkg::ST_UPD_MUL: begin
                prod_next = (Q_WIDTH+9)'(rmax_reg) * $signed({1'b0, disc_reg});
            end
            qtue_pkg::ST_UPD_WR: begin
                if (newq_wide > NW'(QMAX))      newq_next = QMAX;
                else if (newq_wide < NW'(QMIN)) newq_next = QMIN;
                else                            newq_next = Q_WIDTH'(newq_wide);
                // stored before the sweep so every read sees the new value
                q_we    = 1'b1;
                q_waddr = {a_loc, b_loc};
                q_wdata = newq_next;
                idx_next = '0;
            end
            qtue_pkg::ST_UPD_SCAN: begin
                // whole memory swept, entries outside the table skipped
                q_raddr = sweep_addr;
                if (idx_reg < CW'(SWEEP)) begin
                    idx_next = idx_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg && scan_ok) begin
                    sum_next = sum_reg + SW'(q_rdata);
                    if (ridx_reg == '0 || q_rdata > tmax_reg) tmax_next = q_rdata;
                end
            end
            qtue_pkg::ST_UPD_DIV: begin
                if (!div_wait_reg && tmax_reg != '0) begin
                    div_ctl.start     = 1'b1;
                    div_a = DW'(mag);
                    div_b = tmax_reg[Q_WIDTH-1] ? DW'(-tmax_reg) : DW'(tmax_reg);
                    neg_next = scaled[PW-1] ^ tmax_reg[Q_WIDTH-1];
                    div_wait_next = 1'b1;
                end
            end
            qtue_pkg::ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    case (cmd_reg.cmd)
                        qtue_pkg::CMD_SELECT: begin
                            out_next.action = act_reg;
                            out_next.status = !found_reg;
                        end
                        qtue_pkg::CMD_UPDATE: begin
                            if (a_ok && b_ok) begin
                                out_next.new_q = 24'(newq_reg);
                                if (div_wait_reg) begin
                                    qsigned = neg_reg ? -$signed({1'b0, div_q})
                                                      : $signed({1'b0, div_q});
                                    if (qsigned > 65'sd8388607) begin
                                        out_next.score = 24'h7fffff;
                                    end else if (qsigned < -65'sd8388608) begin
                                        out_next.score = 24'h800000;
                                    end else begin
                                        out_next.score = 24'(qsigned);
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // registers, including the clearing pass after reset
    logic init_reg;
    always_ff @(posedge aclk) begin
        ridx_reg <= idx_reg;
        rmax_reg <= rmax_next;
        rcode_reg <= rcode_next;
        prod_reg <= prod_next;
        newq_reg <= newq_next;
        sum_reg  <= sum_next;
        tmax_reg <= tmax_next;
        neg_reg  <= neg_next;
        pick_reg <= pick_next;
        act_reg  <= act_next;
        out_reg  <= out_next;
        if (state_reg == qtue_pkg::ST_IDLE && s_valid && s_ready) cmd_reg <= s_data;
        if (!aresetn) begin
            state_reg     <= qtue_pkg::ST_CLEAR;
            cmd_reg.cmd   <= qtue_pkg::CMD_CLEAR;
            init_reg      <= 1'b1;
            idx_reg       <= '0;
            rv_reg        <= 1'b0;
            step_reg      <= 1'b0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            div_wait_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            // the pass after reset gives no result word
            if (init_reg && state_next == qtue_pkg::ST_DONE) begin
                state_reg <= qtue_pkg::ST_IDLE;
                init_reg  <= 1'b0;
            end else begin
                state_reg <= state_next;
            end
            idx_reg       <= idx_next;
            rv_reg        <= rv_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            div_wait_reg  <= div_wait_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

/* sv/qtue_div.sv */
// serial restoring divider, one quotient bit a cycle, magnitudes
module qtue_div #(
    parameter int W = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] q_reg, q_next;
    logic [W-1:0] r_reg, r_next;
    logic [W-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[W-1]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

/* sv/qtue_mem.sv */
// reward and q storage, one read and one write port each, registered read
module qtue_mem #(
    parameter int AW = 8,
    parameter int QW = 24
) (
    input  logic                 aclk,
    input  logic [AW-1:0]        r_raddr,
    output logic [1:0]           r_rdata,
    input  logic                 r_we,
    input  logic [AW-1:0]        r_waddr,
    input  logic [1:0]           r_wdata,
    input  logic [AW-1:0]        q_raddr,
    output logic signed [QW-1:0] q_rdata,
    input  logic                 q_we,
    input  logic [AW-1:0]        q_waddr,
    input  logic signed [QW-1:0] q_wdata
);
    logic [1:0]           rmem [2**AW];
    logic signed [QW-1:0] qmem [2**AW];

    always_ff @(posedge aclk) begin
        if (r_we) begin
            rmem[r_waddr] <= r_wdata;
        end
        r_rdata <= rmem[r_raddr];
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            qmem[q_waddr] <= q_wdata;
        end
        q_rdata <= qmem[q_raddr];
    end
endmodule

/* sv/qtue_checker.sv */
module qtue_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input qtue_pkg::out_word_t m_data,
    input logic                m_valid,
    input logic                m_ready
);
    // a result waits until it is taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed");

    // one word at a time: after a word is taken the input closes
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while busy");

    // a pending result carries known bits
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !$isunknown(m_data))
        else $error("result word has unknown bits");

    // a failed select reports no action
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.action == 4'd0 && m_data.new_q == '0)
        else $error("bad status word");
endmodule

bind q_table_update_engine qtue_checker u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

/* tb/sv/q_table_update_engine_tb.sv */
`timescale 1ns / 1ps

module q_table_update_engine_tb;

    localparam int N        = 16;
    localparam int WDOG_MAX = 20000;
    localparam int N_RANDOM = 1850;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    qtue_pkg::in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    qtue_pkg::out_word_t m_data;
    logic      cfg_we = 1'b0;
    logic [0:0] cfg_index = qtue_pkg::CFG_END;
    logic [7:0] cfg_data = '0;

    q_table_update_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: reward codes, q values and the two registers
    logic [1:0]         reward_mem [N*N];
    logic signed [23:0] q_mem [N*N];
    logic [3:0]         goal_loc;
    logic [7:0]         gamma;

    qtue_pkg::out_word_t expected_q[$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    bit        quiet_phase = 1'b0;  // long stretch with no idling on either side

    function automatic void wipe_tables();
        for (int i = 0; i < N*N; i++) begin
            reward_mem[i] = qtue_pkg::R_NONE;
            q_mem[i] = '0;
        end
        reward_mem[goal_loc*N + goal_loc] = qtue_pkg::R_GOAL;
    endfunction

    // works out the result word of one command and moves the shadow tables on
    function automatic qtue_pkg::out_word_t predict_word(qtue_pkg::in_word_t w);
        qtue_pkg::out_word_t r;
        int                 cnt, pick;
        logic [3:0]         a, b;
        longint             rmax, tmax, sum, nq, sc, rw;
        r = '0;
        a = w.first_location;
        b = w.second_location;
        case (qtue_pkg::cmd_t'(w.cmd))
            qtue_pkg::CMD_CLEAR: begin
                wipe_tables();
            end
            qtue_pkg::CMD_CONNECT: begin
                reward_mem[a*N + b] = qtue_pkg::R_ZERO;
                reward_mem[b*N + a] = qtue_pkg::R_ZERO;
                if (b == goal_loc) reward_mem[a*N + b] = qtue_pkg::R_GOAL;
            end
            qtue_pkg::CMD_SELECT: begin
                cnt = 0;
                for (int i = 0; i < N; i++)
                    if (reward_mem[a*N + i] != qtue_pkg::R_NONE) cnt++;
                r.status = (cnt == 0);
                if (cnt != 0) begin
                    pick = w.random_value % cnt;
                    for (int i = N - 1; i >= 0; i--)
                        if (reward_mem[a*N + i] != qtue_pkg::R_NONE) begin
                            cnt--;
                            if (cnt == pick) r.action = i[3:0];
                        end
                end
            end
            default: begin
                rmax = q_mem[b*N];
                for (int i = 1; i < N; i++)
                    if (q_mem[b*N + i] > rmax) rmax = q_mem[b*N + i];
                case (reward_mem[a*N + b])
                    qtue_pkg::R_GOAL: rw = 100 * 256;
                    qtue_pkg::R_ZERO: rw = 0;
                    default:          rw = -256;
                endcase
                // >>> on a signed product floors, as the block does
                nq = rw + ((rmax * longint'(gamma)) >>> 8);
                if (nq > 8388607) nq = 8388607;
                if (nq < -8388608) nq = -8388608;
                q_mem[a*N + b] = nq[23:0];
                r.new_q = nq[23:0];
                tmax = q_mem[0];
                sum = 0;
                for (int i = 0; i < N*N; i++) begin
                    sum += q_mem[i];
                    if (q_mem[i] > tmax) tmax = q_mem[i];
                end
                sc = 0;
                if (tmax != 0) begin
                    sc = (sum * 25600) / tmax;
                    if (sc > 8388607) sc = 8388607;
                    if (sc < -8388608) sc = -8388608;
                end
                r.score = sc[23:0];
            end
        endcase
        return r;
    endfunction

    // result side: random stalls and the comparison against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_phase || ($urandom_range(99) >= 7);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_data);
                    fail_count++;
                end else begin
                    qtue_pkg::out_word_t e;
                    e = expected_q.pop_front();
                    if (m_data.action !== e.action) begin
                        $display("%0t: action exp %0d got %0d", $time, e.action, m_data.action);
                        fail_count++;
                    end
                    if (m_data.new_q !== e.new_q) begin
                        $display("%0t: new_q exp %0d got %0d", $time, e.new_q, m_data.new_q);
                        fail_count++;
                    end
                    if (m_data.score !== e.score) begin
                        $display("%0t: score exp %0d got %0d", $time, e.score, m_data.score);
                        fail_count++;
                    end
                    if (m_data.status !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, m_data.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted word on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("Verification failed");
            $finish;
        end
    end

    // hands one word to the block; a checked row carries its typed-in result
    task automatic send_word(qtue_pkg::in_word_t w, bit typed, qtue_pkg::out_word_t typed_res);
        qtue_pkg::out_word_t p;
        while (!quiet_phase && $urandom_range(99) < 7) @(posedge aclk);
        p = predict_word(w);
        if (typed && p !== typed_res) begin
            $display("%0t: table row exp %h predictor %h", $time, typed_res, p);
            fail_count++;
        end
        expected_q.insert(expected_q.size(), typed ? typed_res : p);
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == qtue_pkg::CFG_END) goal_loc = val[3:0];
        else gamma = val;
        @(posedge aclk);
    endtask

    function automatic qtue_pkg::in_word_t mk(qtue_pkg::cmd_t c, int a, int b, int rv);
        qtue_pkg::in_word_t w;
        w.cmd = c;
        w.first_location = a[3:0];
        w.second_location = b[3:0];
        w.random_value = rv[15:0];
        return w;
    endfunction

    function automatic qtue_pkg::out_word_t res(int act, int nq, int sc, int st);
        qtue_pkg::out_word_t r;
        r.action = act[3:0];
        r.new_q = nq[23:0];
        r.score = sc[23:0];
        r.status = st[0];
        return r;
    endfunction

    // random word: mostly updates, then selects and connects, a rare clear, random locations
    function automatic qtue_pkg::in_word_t rand_word();
        int k;
        k = $urandom_range(99);
        if (k < 1)
            return mk(qtue_pkg::CMD_CLEAR, $urandom_range(15), $urandom_range(15), $urandom);
        if (k < 25)
            return mk(qtue_pkg::CMD_CONNECT, $urandom_range(15), $urandom_range(15), $urandom);
        if (k < 50)
            return mk(qtue_pkg::CMD_SELECT, $urandom_range(15), $urandom_range(15), $urandom);
        return mk(qtue_pkg::CMD_UPDATE, $urandom_range(15), $urandom_range(15), $urandom);
    endfunction

    typedef struct {
        qtue_pkg::in_word_t  w;
        bit                  typed;
        qtue_pkg::out_word_t r;
    } stim_row_t;

    stim_row_t dir_tab [15];

    initial begin
        goal_loc = 4'd15;
        gamma    = 8'd205;
        wipe_tables();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table: empty row, goal self loop, unconnected update, extremes
        dir_tab = '{
            '{mk(qtue_pkg::CMD_SELECT, 0, 0, 0),          1, res(0, 0, 0, 1)},
            '{mk(qtue_pkg::CMD_SELECT, 15, 0, 16'hffff),  1, res(15, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_UPDATE, 0, 0, 0),          1, res(0, -256, 0, 0)},
            '{mk(qtue_pkg::CMD_UPDATE, 15, 15, 0),        1, res(0, 25600, 25344, 0)},
            '{mk(qtue_pkg::CMD_CLEAR, 5, 10, 16'h5555),   1, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_CONNECT, 0, 15, 16'hffff), 1, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_CONNECT, 0, 1, 0),         1, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_CONNECT, 15, 14, 0),       0, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_SELECT, 0, 0, 16'hffff),   0, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_SELECT, 0, 3, 16'haaaa),   0, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_UPDATE, 0, 15, 16'hffff),  0, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_UPDATE, 14, 15, 0),        0, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_UPDATE, 15, 15, 0),        0, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_UPDATE, 1, 0, 0),          0, res(0, 0, 0, 0)},
            '{mk(qtue_pkg::CMD_SELECT, 15, 0, 3),         0, res(0, 0, 0, 0)}
        };
        foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].r);
        drain();

        // sweep register settings, extremes included, with random words in each
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(qtue_pkg::CFG_END, 8'd0);
                    write_reg(qtue_pkg::CFG_DISCOUNT, 8'd255);
                end
                1: begin
                    write_reg(qtue_pkg::CFG_END, 8'd15);
                    write_reg(qtue_pkg::CFG_DISCOUNT, 8'd0);
                end
                2: begin
                    write_reg(qtue_pkg::CFG_END, 8'd7);
                    write_reg(qtue_pkg::CFG_DISCOUNT, 8'd128);
                end
                3: begin
                    write_reg(qtue_pkg::CFG_END, 8'hf3);
                    write_reg(qtue_pkg::CFG_DISCOUNT, 8'd255);
                end
                4: begin
                    write_reg(qtue_pkg::CFG_END, 8'd10);
                    write_reg(qtue_pkg::CFG_DISCOUNT, 8'd1);
                end
                default: begin
                    write_reg(qtue_pkg::CFG_END, 8'd15);
                    write_reg(qtue_pkg::CFG_DISCOUNT, 8'd205);
                end
            endcase
            quiet_phase = (ph == 2);
            send_word(mk(qtue_pkg::CMD_CLEAR, 0, 0, 0), 0, '0);
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                send_word(rand_word(), 0, '0);
                // sender hold-off until everything outstanding has come back
                if (i == 100)
                    while (expected_q.size() != 0) @(posedge aclk);
            end
            quiet_phase = 1'b0;
            drain();
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
